FILE: hw/rtl/mgi_pkg.sv
`default_nettype none
package mgi_pkg;

  localparam int CoordBits = 32;
  localparam int SatBits   = (CoordBits < 32) ? CoordBits : 32;
  localparam int MaxGap    = 63;
  localparam int GapBits   = 6;
  localparam int CntBits   = 7;
  localparam int DivSteps  = 34;
  localparam int DivCntW   = 6;
  localparam int NumLanes  = 3;

  localparam logic [31:0] GapCodeReset = 32'hD8F1_0000;
  localparam logic [31:0] GainReset    = 32'h0001_0000;
  localparam logic [8:0]  DecimReset   = 9'd1;

  // register indexes
  localparam logic [1:0] RegGapCode = 2'd0;
  localparam logic [1:0] RegGain    = 2'd1;
  localparam logic [1:0] RegDecim   = 2'd2;

  // origin codes
  localparam logic [1:0] KindMeasured = 2'd0;
  localparam logic [1:0] KindInterp   = 2'd1;
  localparam logic [1:0] KindHeld     = 2'd2;

  typedef enum logic [1:0] {
    SEL_CUR    = 2'd0,
    SEL_ANCHOR = 2'd1,
    SEL_ZERO   = 2'd2,
    SEL_INTERP = 2'd3
  } val_sel_e;

  typedef struct packed {
    logic       capture;
    logic       div_start;
    logic       div_step;
    logic       interp_init;
    logic       interp_step;
    logic       load_val;
    val_sel_e   val_sel;
    logic       load_anchor;
    logic       clear_anchor;
    logic       mul_en;
    logic [7:0] den;
  } lane_ctrl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/marker_gap_interpolator_unit.sv
`default_nettype none
// Gap filler for one marker's stream of Q16.16 3-D positions. An item is taken
// only while the unit is idle. A measured frame with no open gap passes through
// decide, load, multiply and saturate before output valid; a gap closed by
// interpolation first runs a bit-serial divide in each coordinate lane, then
// each interpolated sample goes through step, load, multiply and saturate plus
// any output stall; held samples and the closing measured sample skip the step.
// The x, y and z lanes run in parallel and are merged into one output register.
module marker_gap_interpolator_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,  // pos_x, pos_y, pos_z
  input  wire logic        s_axis_tlast,  // final_frame
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [95:0]      m_axis_tdata,  // out_x, out_y, out_z
  output logic [2:0]       m_axis_tuser,  // origin_kind, stream_end
  output logic             m_axis_tlast   // run_end
);
  import mgi_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_DECIDE = 9'b000000010,
    ST_DIV    = 9'b000000100,
    ST_INIT   = 9'b000001000,
    ST_STEP   = 9'b000010000,
    ST_LOAD   = 9'b000100000,
    ST_MUL    = 9'b001000000,
    ST_SAT    = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [31:0] gap_code_q, gain_q;
  logic [8:0]  decim_q;
  logic [7:0]  skip_q, skip_d;
  logic [GapBits-1:0] pend_q, pend_d;
  logic        av_q, av_d;
  logic        keep_q, final_q;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic        meas_q, meas_d, interp_q, interp_d;
  val_sel_e    hsel_q, hsel_d;
  logic [6:0]  d_q, d_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic [1:0]  kind_q, kind_d;
  logic        last_q, last_d;
  logic [95:0] odata_q;
  logic [2:0]  ouser_q;
  logic        olast_q;

  lane_ctrl_t  ctrl;
  logic [NumLanes-1:0] lane_gap;
  logic [31:0] lane_out [NumLanes];

  logic accept, out_fire, gap_any;
  logic [8:0] dec_eff, skip_inc;
  logic [GapBits-1:0] newp;
  logic [CntBits-1:0] held_c;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;
  assign m_axis_tlast  = olast_q;
  assign gap_any = |lane_gap;

  // decimation counter
  assign dec_eff  = (decim_q == 9'd0) ? 9'd1 : ((decim_q > 9'd256) ? 9'd256 : decim_q);
  assign skip_inc = {1'b0, skip_q} + 9'd1;
  assign skip_d   = s_axis_tlast ? 8'd0 : ((skip_inc >= dec_eff) ? 8'd0 : skip_inc[7:0]);

  // gap bookkeeping for a missing kept sample
  assign newp   = (pend_q == GapBits'(MaxGap)) ? GapBits'(1) : GapBits'(pend_q + 1'b1);
  assign held_c = ((pend_q == GapBits'(MaxGap)) ? CntBits'(MaxGap) : CntBits'(0))
                + (final_q ? CntBits'(newp) : CntBits'(0));

  // sequencer
  always_comb begin
    state_d   = state_q;
    pend_d    = pend_q;
    av_d      = av_q;
    cnt_d     = cnt_q;
    meas_d    = meas_q;
    interp_d  = interp_q;
    hsel_d    = hsel_q;
    d_d       = d_q;
    div_cnt_d = div_cnt_q;
    kind_d    = kind_q;
    last_d    = last_q;
    ctrl          = '0;
    ctrl.val_sel  = SEL_CUR;
    ctrl.den      = {d_q, 1'b0};
    ctrl.capture  = accept;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        hsel_d   = av_q ? SEL_ANCHOR : SEL_ZERO;
        interp_d = 1'b0;
        meas_d   = 1'b0;
        cnt_d    = '0;
        if (keep_q && !gap_any) begin
          meas_d = 1'b1;
          cnt_d  = CntBits'(pend_q);
          pend_d = '0;
          av_d   = 1'b1;
          state_d = ST_LOAD;
          if (pend_q != '0) begin
            if (av_q) begin
              interp_d  = 1'b1;
              d_d       = 7'(pend_q) + 7'd1;
              ctrl.den  = {d_d, 1'b0};
              ctrl.div_start = 1'b1;
              div_cnt_d = '0;
              state_d   = ST_DIV;
            end else begin
              hsel_d = SEL_CUR;
            end
          end
        end else if (keep_q) begin
          pend_d  = newp;
          cnt_d   = held_c;
          state_d = (held_c != '0) ? ST_LOAD : ST_IDLE;
        end else begin
          cnt_d   = (final_q) ? CntBits'(pend_q) : '0;
          state_d = (final_q && pend_q != '0) ? ST_LOAD : ST_IDLE;
        end
        if (final_q) begin
          pend_d = '0;
          av_d   = 1'b0;
          if (state_d == ST_IDLE) ctrl.clear_anchor = 1'b1;
        end
      end
      ST_DIV: begin
        ctrl.div_step = 1'b1;
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == DivCntW'(DivSteps - 1)) state_d = ST_INIT;
      end
      ST_INIT: begin
        ctrl.interp_init = 1'b1;
        state_d = ST_STEP;
      end
      ST_STEP: begin
        ctrl.interp_step = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        ctrl.load_val = 1'b1;
        if (cnt_q != '0) begin
          ctrl.val_sel = interp_q ? SEL_INTERP : hsel_q;
          kind_d = interp_q ? KindInterp : KindHeld;
          last_d = (cnt_q == CntBits'(1)) && !meas_q;
        end else begin
          ctrl.val_sel     = SEL_CUR;
          ctrl.load_anchor = 1'b1;
          kind_d = KindMeasured;
          last_d = 1'b1;
        end
        state_d = ST_MUL;
      end
      ST_MUL: begin
        ctrl.mul_en = 1'b1;
        state_d = ST_SAT;
      end
      ST_SAT: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_fire) begin
          if (last_q) begin
            state_d = ST_IDLE;
            if (final_q) ctrl.clear_anchor = 1'b1;
          end else begin
            cnt_d = cnt_q - 1'b1;
            state_d = (interp_q && cnt_d != '0) ? ST_STEP : ST_LOAD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      gap_code_q <= GapCodeReset;
      gain_q     <= GainReset;
      decim_q    <= DecimReset;
      skip_q     <= '0;
      pend_q     <= '0;
      av_q       <= 1'b0;
      keep_q     <= 1'b0;
      final_q    <= 1'b0;
      cnt_q      <= '0;
      meas_q     <= 1'b0;
      interp_q   <= 1'b0;
      hsel_q     <= SEL_ZERO;
      d_q        <= 7'd1;
      div_cnt_q  <= '0;
      kind_q     <= KindMeasured;
      last_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      pend_q    <= pend_d;
      av_q      <= av_d;
      cnt_q     <= cnt_d;
      meas_q    <= meas_d;
      interp_q  <= interp_d;
      hsel_q    <= hsel_d;
      d_q       <= d_d;
      div_cnt_q <= div_cnt_d;
      kind_q    <= kind_d;
      last_q    <= last_d;
      if (accept) begin
        keep_q  <= (skip_q == 8'd0);
        final_q <= s_axis_tlast;
        skip_q  <= skip_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegGapCode: gap_code_q <= cfg_data_i;
          RegGain:    gain_q     <= cfg_data_i;
          RegDecim:   decim_q    <= cfg_data_i[8:0];
          default:    ;
        endcase
      end
    end
  end

  // coordinate lanes
  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    mgi_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .pos_i      (s_axis_tdata[32*g +: 32]),
      .gap_code_i (gap_code_q),
      .gain_i     (gain_q),
      .is_gap_o   (lane_gap[g]),
      .scaled_o   (lane_out[g])
    );
  end

  // merge lanes into the output register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SAT) begin
      odata_q <= {lane_out[2], lane_out[1], lane_out[0]};
      ouser_q <= {last_q && final_q, kind_q};
      olast_q <= last_q;
    end
  end

  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("output valid while taking input");
  a_accept_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == ST_DECIDE))
    else $error("accepted item not decided");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntBits'(MaxGap + 1))
    else $error("sample count out of range");
  a_stream_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[2]) |-> m_axis_tlast)
    else $error("stream end without run end");

endmodule
`default_nettype wire

FILE: hw/rtl/mgi_lane.sv
`default_nettype none
module mgi_lane (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mgi_pkg::lane_ctrl_t ctrl_i,
  input  wire logic [31:0]        pos_i,
  input  wire logic [31:0]        gap_code_i,
  input  wire logic [31:0]        gain_i,
  output logic                    is_gap_o,
  output logic [31:0]             scaled_o
);
  import mgi_pkg::*;

  logic signed [31:0] anchor_q, cur_q, val_q;
  logic        [33:0] mag_q;
  logic        [7:0]  rem_q, r_q, rd_q;
  logic               neg_q;
  logic signed [34:0] q_q, qd_q;
  logic signed [64:0] prod_q;

  logic signed [32:0] diff;
  logic signed [33:0] two;
  logic        [33:0] mag0;
  logic        [8:0]  trial, rsum;
  logic               ge, wrap;
  logic        [7:0]  rem_d;
  logic signed [34:0] qd_init;
  logic        [7:0]  rd_init;
  logic signed [34:0] interp_sum;
  logic signed [31:0] val_d;
  logic signed [65:0] rounded;
  logic signed [49:0] shifted;

  assign is_gap_o = (cur_q == gap_code_i);

  // signed difference doubled, split into sign and magnitude
  assign diff = {cur_q[31], cur_q} - {anchor_q[31], anchor_q};
  assign two  = {diff, 1'b0};
  assign mag0 = two[33] ? 34'(-two) : 34'(two);

  // one restoring divider step
  assign trial = {rem_q, mag_q[33]};
  assign ge    = (trial >= {1'b0, ctrl_i.den});
  assign rem_d = ge ? 8'(trial - {1'b0, ctrl_i.den}) : trial[7:0];

  // floor quotient and nonnegative remainder
  assign qd_init = neg_q ? ((rem_q != 8'd0) ? (-$signed({1'b0, mag_q}) - 35'sd1)
                                            : -$signed({1'b0, mag_q}))
                         : $signed({1'b0, mag_q});
  assign rd_init = (neg_q && rem_q != 8'd0) ? 8'(ctrl_i.den - rem_q) : rem_q;

  // incremental rounding step
  assign rsum = {1'b0, r_q} + {1'b0, rd_q};
  assign wrap = (rsum >= {1'b0, ctrl_i.den});

  assign interp_sum = 35'(anchor_q) + q_q;

  always_comb begin
    case (ctrl_i.val_sel)
      SEL_CUR:    val_d = cur_q;
      SEL_ANCHOR: val_d = anchor_q;
      SEL_ZERO:   val_d = '0;
      SEL_INTERP: val_d = interp_sum[31:0];
      default:    val_d = '0;
    endcase
  end

  // anchor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_q <= '0;
    end else if (ctrl_i.clear_anchor) begin
      anchor_q <= '0;
    end else if (ctrl_i.load_anchor) begin
      anchor_q <= cur_q;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) cur_q <= pos_i;
    if (ctrl_i.div_start) begin
      mag_q <= mag0;
      neg_q <= two[33];
      rem_q <= '0;
    end else if (ctrl_i.div_step) begin
      mag_q <= {mag_q[32:0], ge};
      rem_q <= rem_d;
    end
    if (ctrl_i.interp_init) begin
      qd_q <= qd_init;
      rd_q <= rd_init;
      q_q  <= '0;
      r_q  <= {1'b0, ctrl_i.den[7:1]};
    end else if (ctrl_i.interp_step) begin
      q_q <= q_q + qd_q + (wrap ? 35'sd1 : 35'sd0);
      r_q <= wrap ? 8'(rsum - {1'b0, ctrl_i.den}) : rsum[7:0];
    end
    if (ctrl_i.load_val) val_q <= val_d;
    if (ctrl_i.mul_en) prod_q <= val_q * $signed({1'b0, gain_i});
  end

  // round, shift and saturate
  assign rounded = 66'(prod_q) + 66'sd32768;
  assign shifted = rounded[65:16];

  always_comb begin
    if (shifted > 50'((64'sd1 <<< (SatBits - 1)) - 64'sd1)) begin
      scaled_o = 32'((64'sd1 <<< (SatBits - 1)) - 64'sd1);
    end else if (shifted < 50'(-(64'sd1 <<< (SatBits - 1)))) begin
      scaled_o = 32'(-(64'sd1 <<< (SatBits - 1)));
    end else begin
      scaled_o = shifted[31:0];
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/marker_gap_interpolator_unit_chk.sv
`timescale 1ns / 1ps
module marker_gap_interpolator_unit_chk
  import mgi_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,   // pos_x, pos_y, pos_z
  input  wire logic        s_axis_tlast,   // final_frame
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [95:0] m_axis_tdata,   // out_x, out_y, out_z
  input  wire logic [2:0]  m_axis_tuser,   // origin_kind, stream_end
  input  wire logic        m_axis_tlast,   // run_end
  output int               fail_cnt_o,
  output int               pend_cnt_o
);

  typedef struct {
    logic [31:0] x, y, z;
    logic [1:0]  kind;
    logic        run_end;
    logic        stream_end;
  } sample_t;

  sample_t     sample_q[$];
  // shadow registers and stream state
  logic [31:0] gap_code_r, gain_r;
  logic [8:0]  decim_r;
  longint      anchor[3];
  bit          anchor_ok;
  int          gap_cnt, skip_cnt;

  assign pend_cnt_o = sample_q.size();

  function automatic longint floor_div(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q--;
    return q;
  endfunction

  function automatic logic [31:0] scale_sat(longint v);
    longint q;
    q = (v * longint'({32'd0, gain_r}) + 32768) >>> 16;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  task automatic push_sample(longint a, longint b, longint c, logic [1:0] kind);
    sample_t s;
    s.x = scale_sat(a);
    s.y = scale_sat(b);
    s.z = scale_sat(c);
    s.kind = kind;
    s.run_end = 1'b0;
    s.stream_end = 1'b0;
    sample_q.push_back(s);
  endtask

  task automatic push_held(int cnt, longint a, longint b, longint c);
    for (int k = 0; k < cnt; k++) push_sample(a, b, c, KindHeld);
  endtask

  // frame in, expected samples out
  task automatic fill_frame(logic [95:0] data, logic last);
    longint cur[3];
    longint hold[3];
    longint dd, diff;
    longint v[3];
    bit     gap, keep;
    int     dec, n0;
    n0 = sample_q.size();
    gap = 0;
    for (int i = 0; i < 3; i++) begin
      cur[i] = longint'($signed(data[32*i +: 32]));
      if (data[32*i +: 32] == gap_code_r) gap = 1;
    end
    dec = int'(decim_r);
    if (dec == 0) dec = 1;
    if (dec > 256) dec = 256;
    keep = (skip_cnt == 0);
    skip_cnt++;
    if (skip_cnt >= dec) skip_cnt = 0;
    for (int i = 0; i < 3; i++) hold[i] = anchor_ok ? anchor[i] : 0;

    if (keep && !gap) begin
      if (gap_cnt > 0) begin
        if (anchor_ok) begin
          dd = gap_cnt + 1;
          for (longint k = 1; k < dd; k++) begin
            for (int i = 0; i < 3; i++) begin
              diff = cur[i] - anchor[i];
              v[i] = anchor[i] + floor_div(2 * diff * k + dd, 2 * dd);
            end
            push_sample(v[0], v[1], v[2], KindInterp);
          end
        end else begin
          push_held(gap_cnt, cur[0], cur[1], cur[2]);
        end
      end
      push_sample(cur[0], cur[1], cur[2], KindMeasured);
      anchor = cur;
      anchor_ok = 1;
      gap_cnt = 0;
    end else if (keep) begin
      if (gap_cnt >= MaxGap) begin
        push_held(gap_cnt, hold[0], hold[1], hold[2]);
        gap_cnt = 0;
      end
      gap_cnt++;
      if (last) begin
        push_held(gap_cnt, hold[0], hold[1], hold[2]);
        gap_cnt = 0;
      end
    end else if (last && gap_cnt > 0) begin
      push_held(gap_cnt, hold[0], hold[1], hold[2]);
      gap_cnt = 0;
    end

    if (sample_q.size() > n0) begin
      sample_q[$].run_end = 1'b1;
      sample_q[$].stream_end = last;
    end
    if (last) begin
      anchor = '{0, 0, 0};
      anchor_ok = 0;
      gap_cnt = 0;
      skip_cnt = 0;
    end
  endtask

  // watch config, input and output channels
  always @(posedge clk_i or negedge rst_ni) begin
    sample_t s;
    if (!rst_ni) begin
      gap_code_r <= GapCodeReset;
      gain_r     <= GainReset;
      decim_r    <= DecimReset;
      anchor     = '{0, 0, 0};
      anchor_ok  = 0;
      gap_cnt    = 0;
      skip_cnt   = 0;
      fail_cnt_o <= 0;
      sample_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegGapCode: gap_code_r <= cfg_data_i;
          RegGain:    gain_r     <= cfg_data_i;
          RegDecim:   decim_r    <= cfg_data_i[8:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) fill_frame(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (sample_q.size() == 0) begin
          $display("%0t: unexpected sample tdata=%h tuser=%h tlast=%b", $time,
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          s = sample_q.pop_front();
          if (m_axis_tdata !== {s.z, s.y, s.x} || m_axis_tuser !== {s.stream_end, s.kind}
              || m_axis_tlast !== s.run_end) begin
            $display("%0t: mismatch exp tdata=%h tuser=%h tlast=%b got tdata=%h tuser=%h tlast=%b",
                     $time, {s.z, s.y, s.x}, {s.stream_end, s.kind}, s.run_end,
                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
    end
  end

endmodule

FILE: tb/sv/marker_gap_interpolator_unit_tb.sv
`timescale 1ns / 1ps
module marker_gap_interpolator_unit_tb;
  import mgi_pkg::*;

  localparam int StallLimit = 3000;
  localparam int LongHold   = 400;
  localparam int Settle     = 80;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [95:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready, m_axis_tlast;
  logic [95:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  int          fail_cnt, pend_cnt;
  int          idle_pct, stall_pct, quiet_cnt;
  bit          long_hold;
  logic [31:0] gap_val;

  marker_gap_interpolator_unit dut (.*);

  marker_gap_interpolator_unit_chk chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .fail_cnt_o(fail_cnt), .pend_cnt_o(pend_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog on cycles with no item moving
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cnt <= 0;
    else quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= StallLimit) begin
      $display("[marker_gap_interpolator_unit] ERROR");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
        long_hold = 0;
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == RegGapCode) gap_val = val;
    @(negedge clk_i);
  endtask

  // all results in, then let the unit settle
  task automatic drain();
    wait (pend_cnt == 0);
    repeat (Settle) @(negedge clk_i);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_frame(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    // the unit is busy deciding for at least this cycle
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(2000000) - 1000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_gap(logic last);
    logic [31:0] c[3];
    int sel;
    foreach (c[i]) c[i] = rnd_coord();
    sel = $urandom_range(3);
    foreach (c[i]) if (sel == 3 || sel == i) c[i] = gap_val;
    send_frame(c[0], c[1], c[2], last);
  endtask

  // one stream: valid frames with gap runs between them
  task automatic send_stream(int len, int max_run);
    int i, run;
    i = 0;
    while (i < len) begin
      if ($urandom_range(99) < 35) begin
        run = $urandom_range(max_run, 1);
        for (int k = 0; k < run && i < len; k++, i++) send_gap(i == len - 1);
      end else begin
        send_frame(rnd_coord(), rnd_coord(), rnd_coord(), i == len - 1);
        i++;
      end
    end
  endtask

  task automatic run_phase(int idle, int stall, int frames);
    idle_pct = idle;
    stall_pct = stall;
    while (frames > 0) begin
      int len;
      len = $urandom_range(12, 2);
      if (len > frames) len = frames;
      send_stream(len, 5);
      frames -= len;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = RegGapCode;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    quiet_cnt = 0;
    long_hold = 0;
    gap_val = GapCodeReset;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, leading gap, interpolated gap, trailing gap
    send_frame(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1);
    send_gap(1'b0);
    send_gap(1'b0);
    send_frame(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 1'b0);
    send_gap(1'b0);
    send_gap(1'b0);
    send_gap(1'b0);
    send_frame(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0003, 1'b0);
    send_gap(1'b0);
    send_gap(1'b1);
    send_gap(1'b1);
    send_frame(32'h0, 32'h0, 32'h0, 1'b0);
    send_frame(32'hFFFF_FFFF, 32'h1, 32'h8000_0001, 1'b1);
    drain();

    // saturating gain, most negative gap code
    write_reg(RegGain, 32'hFFFF_FFFF);
    write_reg(RegGapCode, 32'h8000_0000);
    send_gap(1'b0);
    send_frame(32'h0000_0002, 32'hFFFF_FFFE, 32'h7FFF_FFFF, 1'b0);
    send_gap(1'b0);
    send_frame(32'h8000_0000 + 1, 32'h0, 32'h1234_5678, 1'b1);
    run_phase(0, 0, 10);
    drain();

    // zero gain, keep every third frame, long gap flush
    write_reg(RegGain, 32'h0);
    write_reg(RegGapCode, 32'h7FFF_FFFF);
    write_reg(RegDecim, 32'd3);
    run_phase(53, 0, 14);
    drain();
    write_reg(RegGain, 32'h0001_0000);
    write_reg(RegDecim, 32'd1);
    send_frame(32'h0010_0000, 32'hFFF0_0000, 32'h0, 1'b0);
    for (int i = 0; i < 70; i++) send_gap(1'b0);
    send_frame(32'hFFF0_0000, 32'h0010_0000, 32'h0001_0000, 1'b1);
    drain();

    // receiver hold-off while frames keep coming
    write_reg(RegGapCode, $urandom);
    write_reg(RegGain, $urandom_range(32'h0003_0000));
    long_hold = 1;
    run_phase(0, 53, 14);
    drain();

    // decimation zero and above range, both sides idling
    write_reg(RegDecim, 32'd0);
    write_reg(RegGapCode, GapCodeReset);
    run_phase(21, 21, 10);
    drain();
    write_reg(RegDecim, 32'd511);
    send_stream(4, 2);
    drain();
    write_reg(RegDecim, 32'd256);
    send_stream(3, 2);
    drain();
    write_reg(RegDecim, 32'd2);
    write_reg(RegGain, 32'h0000_8000);
    run_phase(0, 0, 10);

    drain();
    if (fail_cnt == 0) $display("[marker_gap_interpolator_unit] OK");
    else $display("[marker_gap_interpolator_unit] ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/mgi_pkg.sv
hw/rtl/mgi_lane.sv
hw/rtl/marker_gap_interpolator_unit.sv
tb/sv/marker_gap_interpolator_unit_chk.sv
tb/sv/marker_gap_interpolator_unit_tb.sv
